[src/clnws_pkg.sv]
// Types, codes and the microcode ROM of the character LCD nibble write sequencer.
`timescale 1ns / 1ps

package clnws_pkg;

    // Request codes carried on the slave-side tuser.
    typedef enum logic [2:0] {
        FUNC_COMMAND   = 3'd0,
        FUNC_DATA      = 3'd1,
        FUNC_CURSOR    = 3'd2,
        FUNC_INIT      = 3'd3,
        FUNC_CLEAR     = 3'd4,
        FUNC_SHIFT_R   = 3'd5,
        FUNC_SHIFT_L   = 3'd6,
        FUNC_UNDEFINED = 3'd7
    } t_func;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ENABLE_HIGH = 3'd0,
        REG_ENABLE_LOW  = 3'd1,
        REG_COMMAND_GAP = 3'd2,
        REG_POWER_UP    = 3'd3
    } t_reg_index;

    // Where the nibble of a step comes from.
    typedef enum logic [1:0] {
        NIB_HI    = 2'd0,
        NIB_LO    = 2'd1,
        NIB_CONST = 2'd2
    } t_nib_sel;

    // Which hold time a step carries.
    typedef enum logic [1:0] {
        HOLD_HIGH     = 2'd0,
        HOLD_LOW      = 2'd1,
        HOLD_LOW_GAP  = 2'd2,
        HOLD_POWER_UP = 2'd3
    } t_hold_sel;

    typedef struct packed {
        logic [3:0] nib_const;
        t_nib_sel   nib_sel;
        logic       en;
        t_hold_sel  hold_sel;
        logic       last;
    } t_ucode;

    localparam int UC_DEPTH = 25;
    localparam int UC_AW    = 5;

    localparam logic [UC_AW-1:0] UC_BYTE_ENTRY = 5'd0;
    localparam logic [UC_AW-1:0] UC_INIT_ENTRY = 5'd4;
    localparam logic [UC_AW-1:0] UC_LAST_ADDR  = 5'd24;

    // Command bytes of the canned requests and the cursor row bases.
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SHIFT_R  = 8'h1C;
    localparam logic [7:0] CMD_SHIFT_L  = 8'h18;
    localparam logic [7:0] ROW0_BASE    = 8'h80;
    localparam logic [7:0] ROW1_BASE    = 8'hC0;

    // Program: one byte (four steps), then init: power-up wait and
    // commands 0x02, 0x28, 0x0C, 0x06, 0x01.
    localparam t_ucode UCODE [UC_DEPTH] = '{
        '{4'h0, NIB_HI,    1'b1, HOLD_HIGH,     1'b0},
        '{4'h0, NIB_HI,    1'b0, HOLD_LOW,      1'b0},
        '{4'h0, NIB_LO,    1'b1, HOLD_HIGH,     1'b0},
        '{4'h0, NIB_LO,    1'b0, HOLD_LOW,      1'b1},
        '{4'h0, NIB_CONST, 1'b0, HOLD_POWER_UP, 1'b0},
        '{4'h0, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h0, NIB_CONST, 1'b0, HOLD_LOW,      1'b0},
        '{4'h2, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h2, NIB_CONST, 1'b0, HOLD_LOW_GAP,  1'b0},
        '{4'h2, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h2, NIB_CONST, 1'b0, HOLD_LOW,      1'b0},
        '{4'h8, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h8, NIB_CONST, 1'b0, HOLD_LOW_GAP,  1'b0},
        '{4'h0, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h0, NIB_CONST, 1'b0, HOLD_LOW,      1'b0},
        '{4'hC, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'hC, NIB_CONST, 1'b0, HOLD_LOW_GAP,  1'b0},
        '{4'h0, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h0, NIB_CONST, 1'b0, HOLD_LOW,      1'b0},
        '{4'h6, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h6, NIB_CONST, 1'b0, HOLD_LOW_GAP,  1'b0},
        '{4'h0, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h0, NIB_CONST, 1'b0, HOLD_LOW,      1'b0},
        '{4'h1, NIB_CONST, 1'b1, HOLD_HIGH,     1'b0},
        '{4'h1, NIB_CONST, 1'b0, HOLD_LOW_GAP,  1'b1}
    };

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

[src/char_lcd_nibble_write_sequencer_core.sv]
// Top level: microcoded sequencer that expands LCD requests into 4-bit bus pin steps.
`timescale 1ns / 1ps
// A request is registered in the sequencer, each pin step in the output register.
// The single microcode step counter issues one pin step per cycle while the
// master side takes beats. A byte request holds the sequencer for its accept and
// four steps, init for its accept and 21 steps, code 7 for its accept alone.
// Reset (synchronous, active low) returns the sequencer to idle, empties the output register
// and loads the timing registers with 100, 100, 1000 and 100000 us.

module char_lcd_nibble_write_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] byte_value, [8] row, [14:9] column, [15] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    // pin step side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] read_write, [4:1] data_nibble, [5] enable,
                                        // [25:6] hold_us, [31:26] zero
    output logic        m_axis_tuser,   // [0] reg_select
    output logic        m_axis_tlast,   // last step of the request
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Timing registers
    // ------------------------------------------------------------------
    logic [15:0] r_enable_high_us;
    logic [15:0] r_enable_low_us;
    logic [15:0] r_command_gap_us;
    logic [19:0] r_power_up_us;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_high_us <= 16'd100;
            r_enable_low_us  <= 16'd100;
            r_command_gap_us <= 16'd1000;
            r_power_up_us    <= 20'd100000;
        end else if (i_cfg_valid) begin
            // indexes past the list are dropped
            unique case (i_cfg_index)
                clnws_pkg::REG_ENABLE_HIGH: r_enable_high_us <= i_cfg_data[15:0];
                clnws_pkg::REG_ENABLE_LOW:  r_enable_low_us  <= i_cfg_data[15:0];
                clnws_pkg::REG_COMMAND_GAP: r_command_gap_us <= i_cfg_data[15:0];
                clnws_pkg::REG_POWER_UP:    r_power_up_us    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode: pick the byte, register select and program entry
    // ------------------------------------------------------------------
    logic [7:0] w_byte_value;
    logic       w_row;
    logic [5:0] w_column;
    logic [2:0] w_func;
    logic       w_accept;

    assign w_byte_value = s_axis_tdata[7:0];
    assign w_row        = s_axis_tdata[8];
    assign w_column     = s_axis_tdata[14:9];
    assign w_func       = s_axis_tuser;

    clnws_pkg::t_state          r_state, n_state;
    logic [clnws_pkg::UC_AW-1:0] r_pc, n_pc;
    logic [7:0]                 r_byte, n_byte;
    logic                       r_rs, n_rs;

    assign s_axis_tready = (r_state == clnws_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Output register and step issue
    // ------------------------------------------------------------------
    logic        r_out_valid;
    logic        r_out_rs;
    logic [3:0]  r_out_nib;
    logic        r_out_en;
    logic [19:0] r_out_hold;
    logic        r_out_last;

    clnws_pkg::t_ucode w_uc;
    logic              w_issue;
    logic [3:0]        w_nib;
    logic [19:0]       w_hold;
    logic [16:0]       w_low_gap;

    assign w_uc      = clnws_pkg::UCODE[r_pc];
    // advance only when the output register is free or being emptied
    assign w_issue   = (r_state == clnws_pkg::ST_RUN) && (!r_out_valid || m_axis_tready);
    assign w_low_gap = {1'b0, r_enable_low_us} + {1'b0, r_command_gap_us};

    always_comb begin
        case (w_uc.nib_sel)
            clnws_pkg::NIB_HI: w_nib = r_byte[7:4];
            clnws_pkg::NIB_LO: w_nib = r_byte[3:0];
            default:           w_nib = w_uc.nib_const;
        endcase
    end

    always_comb begin
        case (w_uc.hold_sel)
            clnws_pkg::HOLD_HIGH:    w_hold = {4'd0, r_enable_high_us};
            clnws_pkg::HOLD_LOW:     w_hold = {4'd0, r_enable_low_us};
            clnws_pkg::HOLD_LOW_GAP: w_hold = {3'd0, w_low_gap};
            default:                 w_hold = r_power_up_us;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer control
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_byte  = r_byte;
        n_rs    = r_rs;
        unique case (r_state)
            clnws_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_pc    = clnws_pkg::UC_BYTE_ENTRY;
                    n_rs    = 1'b0;
                    n_state = clnws_pkg::ST_RUN;
                    case (w_func)
                        clnws_pkg::FUNC_COMMAND: n_byte = w_byte_value;
                        clnws_pkg::FUNC_DATA: begin
                            n_byte = w_byte_value;
                            n_rs   = 1'b1;
                        end
                        clnws_pkg::FUNC_CURSOR:
                            n_byte = (w_row ? clnws_pkg::ROW1_BASE : clnws_pkg::ROW0_BASE)
                                     + {2'd0, w_column};
                        clnws_pkg::FUNC_INIT:    n_pc   = clnws_pkg::UC_INIT_ENTRY;
                        clnws_pkg::FUNC_CLEAR:   n_byte = clnws_pkg::CMD_CLEAR;
                        clnws_pkg::FUNC_SHIFT_R: n_byte = clnws_pkg::CMD_SHIFT_R;
                        clnws_pkg::FUNC_SHIFT_L: n_byte = clnws_pkg::CMD_SHIFT_L;
                        // undefined code: swallow the beat, no steps
                        default:                 n_state = clnws_pkg::ST_IDLE;
                    endcase
                end
            end
            clnws_pkg::ST_RUN: begin
                if (w_issue) begin
                    // the last flag of the control word ends the program
                    if (w_uc.last) begin
                        n_state = clnws_pkg::ST_IDLE;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            default: n_state = clnws_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clnws_pkg::ST_IDLE;
            r_pc        <= clnws_pkg::UC_BYTE_ENTRY;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (w_issue) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_rs   <= n_rs;
        if (w_issue) begin
            r_out_rs   <= r_rs && (w_uc.nib_sel != clnws_pkg::NIB_CONST);
            r_out_nib  <= w_nib;
            r_out_en   <= w_uc.en;
            r_out_hold <= w_hold;
            r_out_last <= w_uc.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_hold, r_out_en, r_out_nib, 1'b0};
    assign m_axis_tuser  = r_out_rs;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // init request starts the program at the power-up wait step
    a_init_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_func == clnws_pkg::FUNC_INIT))
        |=> (r_state == clnws_pkg::ST_RUN) && (r_pc == clnws_pkg::UC_INIT_ENTRY))
        else $error("init request did not enter the init program");

    // the step counter never runs past the end of the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clnws_pkg::ST_RUN) |-> (r_pc <= clnws_pkg::UC_LAST_ADDR))
        else $error("step counter ran past the program");

    // issuing the final word returns the sequencer to idle with tlast shown
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_uc.last)
        |=> (r_state == clnws_pkg::ST_IDLE) && m_axis_tvalid && m_axis_tlast)
        else $error("final step did not end the request");

    // a new request is never taken while a program is running
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clnws_pkg::ST_RUN) |-> !w_accept)
        else $error("request accepted during a running program");
`endif

endmodule

[sim/char_lcd_nibble_write_sequencer_core_test.sv]
// Self-checking testbench for the character LCD nibble write sequencer.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_core_test;

    localparam int WATCHDOG_LIMIT     = 1000;
    localparam int SETTLE_CYCLES      = 8;    // a code 7 request can still be in flight
    localparam int MAX_WAIT           = 17;
    localparam int RANDOM_PHASES      = 6;
    localparam int REQUESTS_PER_PHASE = 50;

    // First register index past the register file; writes there must be dropped.
    localparam logic [2:0] REG_INDEX_UNUSED = 3'd4;

    localparam logic [7:0] INIT_COMMANDS [5] = '{8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};

    // Requests that expand to a single byte, used to weight the random mix.
    localparam clnws_pkg::t_func BYTE_FUNCS [6] = '{
        clnws_pkg::FUNC_COMMAND, clnws_pkg::FUNC_DATA, clnws_pkg::FUNC_CURSOR,
        clnws_pkg::FUNC_CLEAR, clnws_pkg::FUNC_SHIFT_R, clnws_pkg::FUNC_SHIFT_L};

    typedef struct {
        logic        reg_select;
        logic        read_write;
        logic [3:0]  data_nibble;
        logic        enable;
        logic [19:0] hold_us;
        logic        last;
    } t_pin_step;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [19:0] i_cfg_data    = '0;

    // Timing registers as the block should hold them.
    logic [15:0] enable_high_us = 16'd100;
    logic [15:0] enable_low_us  = 16'd100;
    logic [15:0] command_gap_us = 16'd1000;
    logic [19:0] power_up_us    = 20'd100000;

    t_pin_step pin_steps_due [$];
    t_pin_step step_want;
    int        error_count   = 0;
    int        quiet_cycles  = 0;
    int        request_gap   = 0;
    bit        src_idle_en   = 1'b1;
    bit        sink_idle_en  = 1'b1;

    char_lcd_nibble_write_sequencer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Queue the four pin steps of one byte: high nibble, then low nibble,
    // each as enable high followed by enable low.
    function automatic void queue_byte_steps(input logic rs, input logic [7:0] b,
                                             input logic [19:0] extra, input logic last);
        pin_steps_due.push_back('{rs, 1'b0, b[7:4], 1'b1, 20'(enable_high_us), 1'b0});
        pin_steps_due.push_back('{rs, 1'b0, b[7:4], 1'b0, 20'(enable_low_us), 1'b0});
        pin_steps_due.push_back('{rs, 1'b0, b[3:0], 1'b1, 20'(enable_high_us), 1'b0});
        pin_steps_due.push_back('{rs, 1'b0, b[3:0], 1'b0, 20'(enable_low_us) + extra, last});
    endfunction

    function automatic void expand_request(input clnws_pkg::t_func f, input logic [7:0] b,
                                           input logic r, input logic [5:0] c);
        logic [7:0] cursor_addr;
        cursor_addr = (r ? clnws_pkg::ROW1_BASE : clnws_pkg::ROW0_BASE) + {2'b00, c};
        case (f)
            clnws_pkg::FUNC_COMMAND: queue_byte_steps(1'b0, b, 20'd0, 1'b1);
            clnws_pkg::FUNC_DATA:    queue_byte_steps(1'b1, b, 20'd0, 1'b1);
            clnws_pkg::FUNC_CURSOR:  queue_byte_steps(1'b0, cursor_addr, 20'd0, 1'b1);
            clnws_pkg::FUNC_INIT: begin
                // power-up wait with every pin low, then the command list
                pin_steps_due.push_back('{1'b0, 1'b0, 4'h0, 1'b0, power_up_us, 1'b0});
                for (int i = 0; i < 5; i++)
                    queue_byte_steps(1'b0, INIT_COMMANDS[i], 20'(command_gap_us), i == 4);
            end
            clnws_pkg::FUNC_CLEAR:   queue_byte_steps(1'b0, clnws_pkg::CMD_CLEAR, 20'd0, 1'b1);
            clnws_pkg::FUNC_SHIFT_R: queue_byte_steps(1'b0, clnws_pkg::CMD_SHIFT_R, 20'd0, 1'b1);
            clnws_pkg::FUNC_SHIFT_L: queue_byte_steps(1'b0, clnws_pkg::CMD_SHIFT_L, 20'd0, 1'b1);
            default: ;    // undefined code: no steps
        endcase
    endfunction

    // Present one request and hold it until the block takes the beat. The
    // valid stays up when the next gap is zero, so back-to-back beats run.
    task automatic send_request(input clnws_pkg::t_func f, input logic [7:0] b,
                                input logic r, input logic [5:0] c);
        repeat (request_gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, c, r, b};
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        expand_request(f, b, r, c);
        request_gap = src_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
        if (request_gap > 0) begin
            // drop valid and put noise on the idle bus
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            s_axis_tuser  <= 3'($urandom);
        end
    endtask

    task automatic end_burst();
        if (request_gap == 0)
            s_axis_tvalid <= 1'b0;
        request_gap = 1;
    endtask

    // Drain every pending pin step, then let a trailing code 7 request settle.
    task automatic wait_idle();
        end_burst();
        while (pin_steps_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [19:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            clnws_pkg::REG_ENABLE_HIGH: enable_high_us = value[15:0];
            clnws_pkg::REG_ENABLE_LOW:  enable_low_us  = value[15:0];
            clnws_pkg::REG_COMMAND_GAP: command_gap_us = value[15:0];
            clnws_pkg::REG_POWER_UP:    power_up_us    = value;
            default: ;
        endcase
    endtask

    function automatic logic [19:0] draw_reg_value();
        case ($urandom_range(0, 5))
            0:       return 20'd0;
            1:       return 20'd1;
            2:       return 20'hFFFFF;
            3:       return 20'($urandom_range(0, 255));
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_request(clnws_pkg::FUNC_DATA, 8'h41, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_INIT, 8'h00, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_COMMAND, 8'h80, 1'b0, 6'd0);
    endtask

    task automatic test_directed_requests();
        send_request(clnws_pkg::FUNC_COMMAND, 8'h00, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_COMMAND, 8'hFF, 1'b1, 6'd63);
        send_request(clnws_pkg::FUNC_DATA, 8'h00, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_DATA, 8'hFF, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_DATA, 8'hA5, 1'b1, 6'd21);
        send_request(clnws_pkg::FUNC_COMMAND, 8'h5A, 1'b0, 6'd42);
        send_request(clnws_pkg::FUNC_CURSOR, 8'hFF, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_CURSOR, 8'h00, 1'b0, 6'd39);
        send_request(clnws_pkg::FUNC_CURSOR, 8'h00, 1'b1, 6'd0);
        send_request(clnws_pkg::FUNC_CURSOR, 8'h00, 1'b1, 6'd39);
        // columns past the visible line still just add to the row base
        send_request(clnws_pkg::FUNC_CURSOR, 8'h00, 1'b0, 6'd63);
        send_request(clnws_pkg::FUNC_CURSOR, 8'h00, 1'b1, 6'd63);
        // canned commands ignore the byte, row and column fields
        send_request(clnws_pkg::FUNC_CLEAR, 8'hFF, 1'b1, 6'd63);
        send_request(clnws_pkg::FUNC_SHIFT_R, 8'h00, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_SHIFT_L, 8'hFF, 1'b1, 6'd63);
        // undefined code: no steps, and the following request is unaffected
        send_request(clnws_pkg::FUNC_UNDEFINED, 8'hFF, 1'b1, 6'd63);
        send_request(clnws_pkg::FUNC_DATA, 8'h3C, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_UNDEFINED, 8'h00, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_INIT, 8'hFF, 1'b1, 6'd63);
    endtask

    task automatic test_register_extremes();
        // largest holds: init gap step reaches 0x1FFFE
        write_reg(clnws_pkg::REG_ENABLE_HIGH, 20'h0FFFF);
        write_reg(clnws_pkg::REG_ENABLE_LOW, 20'h0FFFF);
        write_reg(clnws_pkg::REG_COMMAND_GAP, 20'h0FFFF);
        write_reg(clnws_pkg::REG_POWER_UP, 20'hFFFFF);
        send_request(clnws_pkg::FUNC_INIT, 8'h00, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_DATA, 8'hFF, 1'b0, 6'd0);

        // zero holds pass through
        write_reg(clnws_pkg::REG_ENABLE_HIGH, 20'd0);
        write_reg(clnws_pkg::REG_ENABLE_LOW, 20'd0);
        write_reg(clnws_pkg::REG_COMMAND_GAP, 20'd0);
        write_reg(clnws_pkg::REG_POWER_UP, 20'd0);
        send_request(clnws_pkg::FUNC_INIT, 8'h00, 1'b0, 6'd0);
        send_request(clnws_pkg::FUNC_COMMAND, 8'hC3, 1'b0, 6'd0);

        // upper data bits must be cut off on the 16-bit registers
        write_reg(clnws_pkg::REG_ENABLE_HIGH, 20'hA0001);
        write_reg(clnws_pkg::REG_ENABLE_LOW, 20'h5FFFF);
        write_reg(clnws_pkg::REG_COMMAND_GAP, 20'hF0000);
        write_reg(clnws_pkg::REG_POWER_UP, 20'd1);
        send_request(clnws_pkg::FUNC_INIT, 8'h00, 1'b0, 6'd0);

        // writes past the register file change nothing
        for (int idx = REG_INDEX_UNUSED; idx < 8; idx++)
            write_reg(3'(idx), 20'($urandom));
        send_request(clnws_pkg::FUNC_DATA, 8'h96, 1'b1, 6'd5);
        send_request(clnws_pkg::FUNC_INIT, 8'h00, 1'b0, 6'd0);
    endtask

    task automatic test_random_traffic();
        int               pick;
        clnws_pkg::t_func f;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // first phases run with one or both sides never pausing
            src_idle_en  = (phase != 0) && (phase != 2);
            sink_idle_en = (phase != 0) && (phase != 1);
            write_reg(clnws_pkg::REG_ENABLE_HIGH, draw_reg_value());
            write_reg(clnws_pkg::REG_ENABLE_LOW, draw_reg_value());
            write_reg(clnws_pkg::REG_COMMAND_GAP, draw_reg_value());
            write_reg(clnws_pkg::REG_POWER_UP, draw_reg_value());
            for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    f = clnws_pkg::FUNC_INIT;
                else if (pick < 16)
                    f = clnws_pkg::FUNC_UNDEFINED;
                else
                    f = BYTE_FUNCS[$urandom_range(0, 5)];
                send_request(f, 8'($urandom), 1'($urandom), 6'($urandom));
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_requests();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Pin step sink: while pauses are enabled, pause a random number of cycles before each beat.
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = sink_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare each pin step beat with the oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pin_steps_due.size() == 0) begin
                $error("pin step beat with no step pending: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                step_want = pin_steps_due.pop_front();
                if (m_axis_tuser !== step_want.reg_select) begin
                    $error("reg_select: expected %0d, got %0d",
                           step_want.reg_select, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[0] !== step_want.read_write) begin
                    $error("read_write: expected %0d, got %0d",
                           step_want.read_write, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[4:1] !== step_want.data_nibble) begin
                    $error("data_nibble: expected %h, got %h",
                           step_want.data_nibble, m_axis_tdata[4:1]);
                    error_count++;
                end
                if (m_axis_tdata[5] !== step_want.enable) begin
                    $error("enable: expected %0d, got %0d",
                           step_want.enable, m_axis_tdata[5]);
                    error_count++;
                end
                if (m_axis_tdata[25:6] !== step_want.hold_us) begin
                    $error("hold_us: expected %0d, got %0d",
                           step_want.hold_us, m_axis_tdata[25:6]);
                    error_count++;
                end
                if (m_axis_tlast !== step_want.last) begin
                    $error("last: expected %0d, got %0d", step_want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[sim.f]
src/clnws_pkg.sv
src/char_lcd_nibble_write_sequencer_core.sv
sim/char_lcd_nibble_write_sequencer_core_test.sv
